// ===== hdl/ffbp_pkg.sv =====
`default_nettype none

package ffbp_pkg;

   // default geometry
   localparam int MAX_BINS_DEFAULT  = 64;
   localparam int SIZE_BITS_DEFAULT = 16;

   // fixed port widths
   localparam int ITEM_W      = 16;
   localparam int CAP_W       = 16;
   localparam int BIN_INDEX_W = 6;
   localparam int BINS_W      = 7;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

   // one placement result
   typedef struct packed {
      logic [BIN_INDEX_W-1:0] bin_index;
      logic                   opened_new;
      logic                   oversize;
      logic                   no_room;
      logic [BINS_W-1:0]      bins_in_use;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/ffbp_room_mem.sv =====
`default_nettype none

module ffbp_room_mem #(
   parameter int MAX_BINS  = ffbp_pkg::MAX_BINS_DEFAULT,
   parameter int SIZE_BITS = ffbp_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(MAX_BINS)-1:0] rd_addr,
   output logic      [SIZE_BITS-1:0]        rd_data,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(MAX_BINS)-1:0] wr_addr,
   input  wire logic [SIZE_BITS-1:0]        wr_data
);
   import ffbp_pkg::*;

   logic [SIZE_BITS-1:0] room_mem [MAX_BINS];
   logic [SIZE_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         room_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= room_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/ffbp_engine.sv =====
`default_nettype none

module ffbp_engine #(
   parameter int MAX_BINS  = ffbp_pkg::MAX_BINS_DEFAULT,
   parameter int SIZE_BITS = ffbp_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // item input
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [ffbp_pkg::ITEM_W-1:0]      req_item_size,
   input  wire logic                             req_start_new,
   // settings and result hand-off
   input  wire logic [SIZE_BITS-1:0]             capacity,
   input  wire logic                             place_ready,
   output logic                                  res_valid,
   output ffbp_pkg::result_type                  res,
   // room memory
   output logic                                  rd_en,
   output logic      [$clog2(MAX_BINS)-1:0]      rd_addr,
   input  wire logic [SIZE_BITS-1:0]             rd_data,
   output logic                                  wr_en,
   output logic      [$clog2(MAX_BINS)-1:0]      wr_addr,
   output logic      [SIZE_BITS-1:0]             wr_data
);
   import ffbp_pkg::*;

   localparam int AW = $clog2(MAX_BINS);
   localparam int CW = $clog2(MAX_BINS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BINS);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_PLACE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        addr_ff, addr_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [CW-1:0]        chk_idx_ff, chk_idx_in;
   logic                 fit_ff, fit_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [SIZE_BITS-1:0] room_ff, room_in;

   logic                         accept;
   logic [SIZE_BITS+ITEM_W-1:0]  size_wide;
   logic                         fits;
   logic                         last_bin;
   logic                         oversize;
   logic [CW-1:0]                count_next;
   logic [AW+BIN_INDEX_W-1:0]    idx_wide;
   logic [AW+BIN_INDEX_W-1:0]    new_idx_wide;
   logic [CW+BINS_W-1:0]         count_wide;
   logic [CW+BINS_W-1:0]         count_next_wide;

   // item size taken to the internal width
   assign size_wide = {{SIZE_BITS{1'b0}}, req_item_size};

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // scan compare on the room just read
   assign fits     = (rd_data >= size_ff);
   assign last_bin = (chk_idx_ff == count_ff - CW'(1));

   // new-bin figures
   assign oversize        = (size_ff > capacity);
   assign count_next      = count_ff + CW'(1);
   assign idx_wide        = {{BIN_INDEX_W{1'b0}}, idx_ff};
   assign new_idx_wide    = {{BIN_INDEX_W{1'b0}}, count_ff[AW-1:0]};
   assign count_wide      = {{BINS_W{1'b0}}, count_ff};
   assign count_next_wide = {{BINS_W{1'b0}}, count_next};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      fit_in       = fit_ff;
      idx_in       = idx_ff;
      room_in      = room_ff;
      rd_en        = 1'b0;
      rd_addr      = addr_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = room_ff;
      res_valid    = 1'b0;
      res          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               size_in  = size_wide[SIZE_BITS-1:0];
               count_in = req_start_new ? '0 : count_ff;
               addr_in  = '0;
               fit_in   = 1'b0;
               if (req_start_new || (count_ff == '0)) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (chk_valid_ff && fits) begin
               // first bin with enough room
               fit_in   = 1'b1;
               idx_in   = chk_idx_ff[AW-1:0];
               room_in  = rd_data - size_ff;
               state_in = ST_PLACE;
            end else if (chk_valid_ff && last_bin) begin
               // every open bin checked, none fits
               fit_in   = 1'b0;
               state_in = ST_PLACE;
            end else begin
               // read the next open bin
               rd_en        = (addr_ff < count_ff);
               chk_valid_in = rd_en;
               chk_idx_in   = addr_ff;
               addr_in      = addr_ff + CW'(1);
            end
         end

         ST_PLACE: begin
            if (place_ready) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
               priority if (fit_ff) begin
                  // write back the reduced room
                  wr_en           = 1'b1;
                  wr_addr         = idx_ff;
                  wr_data         = room_ff;
                  res.bin_index   = idx_wide[BIN_INDEX_W-1:0];
                  res.bins_in_use = count_wide[BINS_W-1:0];
               end else if (count_ff != COUNT_MAX) begin
                  // open a fresh bin
                  wr_en           = 1'b1;
                  wr_addr         = count_ff[AW-1:0];
                  wr_data         = oversize ? '0 : capacity - size_ff;
                  count_in        = count_next;
                  res.bin_index   = new_idx_wide[BIN_INDEX_W-1:0];
                  res.opened_new  = 1'b1;
                  res.oversize    = oversize;
                  res.bins_in_use = count_next_wide[BINS_W-1:0];
               end else begin
                  // all bins used, item dropped
                  res.no_room     = 1'b1;
                  res.bins_in_use = count_wide[BINS_W-1:0];
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      size_ff    <= size_in;
      addr_ff    <= addr_in;
      chk_idx_ff <= chk_idx_in;
      fit_ff     <= fit_in;
      idx_ff     <= idx_in;
      room_ff    <= room_in;
   end

endmodule

`default_nettype wire

// ===== hdl/first_fit_bin_packer_core.sv =====
// An item is accepted, the open bins are scanned (one room memory read a
// cycle; no scan when no bin is open or start_new is set), and the item is
// placed once the output register can take it; the result is registered onto
// rsp_. No new item is taken until the last is placed; a waiting item does
// not hold up the scan of the next one. Reset (synchronous) closes all bins,
// sets capacity to 65535 and empties the output; room memory is not cleared.
`default_nettype none

module first_fit_bin_packer_core #(
   parameter int MAX_BINS  = ffbp_pkg::MAX_BINS_DEFAULT,
   parameter int SIZE_BITS = ffbp_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration
   input  wire logic                               csr_wr_en,
   input  wire logic [ffbp_pkg::CAP_W-1:0]         csr_wr_data,
   // item input
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [ffbp_pkg::ITEM_W-1:0]        req_item_size,
   input  wire logic                               req_start_new,
   // result output
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [ffbp_pkg::BIN_INDEX_W-1:0]   rsp_bin_index,
   output logic                                    rsp_opened_new,
   output logic                                    rsp_oversize,
   output logic                                    rsp_no_room,
   output logic      [ffbp_pkg::BINS_W-1:0]        rsp_bins_in_use
);
   import ffbp_pkg::*;

   localparam int AW = $clog2(MAX_BINS);

   logic [SIZE_BITS-1:0]       capacity_ff, capacity_in;
   logic [SIZE_BITS+CAP_W-1:0] cap_wr_wide;
   logic [SIZE_BITS+CAP_W-1:0] cap_rst_wide;
   logic                       rsp_valid_ff, rsp_valid_in;
   result_type                 rsp_data_ff, rsp_data_in;

   logic                 place_ready;
   logic                 res_valid;
   result_type           res;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [SIZE_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [SIZE_BITS-1:0] wr_data;

   // capacity register
   assign cap_wr_wide  = {{SIZE_BITS{1'b0}}, csr_wr_data};
   assign cap_rst_wide = {{SIZE_BITS{1'b0}}, CAP_RESET};
   assign capacity_in  = csr_wr_en ? cap_wr_wide[SIZE_BITS-1:0] : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= cap_rst_wide[SIZE_BITS-1:0];
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // output register
   assign place_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_index   = rsp_data_ff.bin_index;
   assign rsp_opened_new  = rsp_data_ff.opened_new;
   assign rsp_oversize    = rsp_data_ff.oversize;
   assign rsp_no_room     = rsp_data_ff.no_room;
   assign rsp_bins_in_use = rsp_data_ff.bins_in_use;

   // search and placement sequencer
   ffbp_engine #(
      .MAX_BINS  (MAX_BINS),
      .SIZE_BITS (SIZE_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item_size (req_item_size),
      .req_start_new (req_start_new),
      .capacity      (capacity_ff),
      .place_ready   (place_ready),
      .res_valid     (res_valid),
      .res           (res),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   // bin room storage
   ffbp_room_mem #(
      .MAX_BINS  (MAX_BINS),
      .SIZE_BITS (SIZE_BITS)
   ) u_room_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

`default_nettype wire

// ===== hdl/ffbp_checker.sv =====
`default_nettype none

module ffbp_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [ffbp_pkg::BIN_INDEX_W-1:0]   rsp_bin_index,
   input wire logic                               rsp_opened_new,
   input wire logic                               rsp_oversize,
   input wire logic                               rsp_no_room,
   input wire logic [ffbp_pkg::BINS_W-1:0]        rsp_bins_in_use
);
   import ffbp_pkg::*;

   // a stalled item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item withdrawn while stalled");

   // a stalled item keeps its fields
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_bin_index) && $stable(rsp_opened_new)
         && $stable(rsp_oversize) && $stable(rsp_no_room) && $stable(rsp_bins_in_use))
      else $error("rsp item changed while stalled");

   // a dropped item reports no placement
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_room |-> !rsp_opened_new && !rsp_oversize
         && (rsp_bin_index == '0) && (rsp_bins_in_use != '0))
      else $error("dropped item reports a placement");

   // oversize only on a freshly opened bin
   a_over_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_oversize |-> rsp_opened_new)
      else $error("oversize without a new bin");

   // a new bin leaves at least one bin open
   a_new_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opened_new |-> (rsp_bins_in_use != '0) && !rsp_no_room)
      else $error("new bin with no bin in use");

endmodule

bind first_fit_bin_packer_core ffbp_checker u_ffbp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_bin_index   (rsp_bin_index),
   .rsp_opened_new  (rsp_opened_new),
   .rsp_oversize    (rsp_oversize),
   .rsp_no_room     (rsp_no_room),
   .rsp_bins_in_use (rsp_bins_in_use)
);

`default_nettype wire

// ===== tb/sv/tb_first_fit_bin_packer_core.sv =====
`default_nettype none

module tb_first_fit_bin_packer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ffbp_pkg::*;

   localparam int NBINS        = MAX_BINS_DEFAULT;
   localparam int RANDOM_ITEMS = 770;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE       = NBINS + 8;

   typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_type;

   // one line of the directed plan: an item (repeated reps times) or a capacity write
   typedef struct packed {
      row_kind_type     kind;
      logic [ITEM_W-1:0] value;
      logic             start;
      logic [6:0]       reps;
      logic             checked;
      result_type       want;
   } plan_row_type;

   localparam result_type NO_WANT = '0;
   localparam int         PLAN_ROWS = 25;

   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // default capacity: empty start, full-size fit, zero-size items
      '{ROW_ITEM, 16'd0,     1'b0, 7'd1,  1'b1, '{6'd0, 1'b1, 1'b0, 1'b0, 7'd1}},
      '{ROW_ITEM, 16'hFFFF,  1'b0, 7'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 7'd1}},
      '{ROW_ITEM, 16'd1,     1'b0, 7'd1,  1'b1, '{6'd1, 1'b1, 1'b0, 1'b0, 7'd2}},
      '{ROW_ITEM, 16'd0,     1'b0, 7'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 7'd2}},
      '{ROW_ITEM, 16'd40000, 1'b0, 7'd1,  1'b0, NO_WANT},
      // zero capacity: every nonzero item is oversize
      '{ROW_CAP,  16'd0,     1'b0, 7'd1,  1'b0, NO_WANT},
      '{ROW_ITEM, 16'd1,     1'b1, 7'd1,  1'b1, '{6'd0, 1'b1, 1'b1, 1'b0, 7'd1}},
      '{ROW_ITEM, 16'd0,     1'b0, 7'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 7'd1}},
      '{ROW_ITEM, 16'hFFFF,  1'b0, 7'd1,  1'b1, '{6'd1, 1'b1, 1'b1, 1'b0, 7'd2}},
      // capacity lowered under an open bin that still has more room
      '{ROW_CAP,  16'd1000,  1'b0, 7'd1,  1'b0, NO_WANT},
      '{ROW_ITEM, 16'd10,    1'b1, 7'd1,  1'b1, '{6'd0, 1'b1, 1'b0, 1'b0, 7'd1}},
      '{ROW_CAP,  16'd100,   1'b0, 7'd1,  1'b0, NO_WANT},
      '{ROW_ITEM, 16'd500,   1'b0, 7'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 7'd1}},
      '{ROW_ITEM, 16'd491,   1'b0, 7'd1,  1'b1, '{6'd1, 1'b1, 1'b1, 1'b0, 7'd2}},
      '{ROW_ITEM, 16'd100,   1'b0, 7'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 7'd2}},
      // exact fit into the remaining room
      '{ROW_CAP,  16'hFFFF,  1'b0, 7'd1,  1'b0, NO_WANT},
      '{ROW_ITEM, 16'd32768, 1'b1, 7'd1,  1'b0, NO_WANT},
      '{ROW_ITEM, 16'd32767, 1'b0, 7'd1,  1'b0, NO_WANT},
      // fill every bin, then overflow
      '{ROW_CAP,  16'd0,     1'b0, 7'd1,  1'b0, NO_WANT},
      '{ROW_ITEM, 16'd7,     1'b1, 7'd64, 1'b0, NO_WANT},
      '{ROW_ITEM, 16'd9,     1'b0, 7'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b1, 7'd64}},
      '{ROW_ITEM, 16'd0,     1'b0, 7'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 7'd64}},
      '{ROW_ITEM, 16'hAAAA,  1'b1, 7'd1,  1'b1, '{6'd0, 1'b1, 1'b1, 1'b0, 7'd1}},
      '{ROW_ITEM, 16'h5555,  1'b0, 7'd1,  1'b1, '{6'd1, 1'b1, 1'b1, 1'b0, 7'd2}},
      '{ROW_CAP,  16'hFFFF,  1'b0, 7'd1,  1'b0, NO_WANT}
   };

   // clock, reset and block inputs
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [CAP_W-1:0]   csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic [ITEM_W-1:0]  req_item_size = '0;
   logic               req_start_new = 1'b0;
   logic               rsp_stall = 1'b0;

   // block outputs
   logic                   req_stall;
   logic                   rsp_valid;
   logic [BIN_INDEX_W-1:0] rsp_bin_index;
   logic                   rsp_opened_new;
   logic                   rsp_oversize;
   logic                   rsp_no_room;
   logic [BINS_W-1:0]      rsp_bins_in_use;

   // packing state mirrored by the testbench
   logic [ITEM_W-1:0] bin_room_left [NBINS];
   int                bins_open;
   logic [CAP_W-1:0]  capacity_now;

   result_type placements_due [$];
   result_type placement_head;

   bit valid_up;
   int mismatches;
   int items_sent;
   int random_sent;
   int results_seen;
   int oversize_seen;
   int drops_seen;
   int cap_writes;
   int cycle_count;
   int stall_run;
   int stall_draw;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   first_fit_bin_packer_core DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item_size   (req_item_size),
      .req_start_new   (req_start_new),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_opened_new  (rsp_opened_new),
      .rsp_oversize    (rsp_oversize),
      .rsp_no_room     (rsp_no_room),
      .rsp_bins_in_use (rsp_bins_in_use)
   );

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] %s", $time, what);
   endtask

   // first-fit placement of one item, updating the mirrored bins
   function automatic result_type place_item(input logic [ITEM_W-1:0] size, input logic start);
      result_type res;
      int slot;
      int i;
      res = '0;
      slot = -1;
      if (start) bins_open = 0;
      for (i = 0; i < bins_open; i++) begin
         if (slot < 0 && bin_room_left[i] >= size) slot = i;
      end
      if (slot >= 0) begin
         bin_room_left[slot] = bin_room_left[slot] - size;
         res.bin_index = slot[BIN_INDEX_W-1:0];
      end else if (bins_open < NBINS) begin
         res.bin_index = bins_open[BIN_INDEX_W-1:0];
         res.opened_new = 1'b1;
         if (size > capacity_now) begin
            res.oversize = 1'b1;
            bin_room_left[bins_open] = '0;
         end else begin
            bin_room_left[bins_open] = capacity_now - size;
         end
         bins_open++;
      end else begin
         res.no_room = 1'b1;
      end
      res.bins_in_use = bins_open[BINS_W-1:0];
      return res;
   endfunction

   // size mix aimed at exact fits, capacity edges and filling bins fast
   function automatic logic [ITEM_W-1:0] pick_size();
      int draw;
      int cap;
      int slot;
      draw = $urandom_range(99);
      cap = int'(capacity_now);
      if (draw < 8) return '0;
      if (draw < 18) return ITEM_W'($urandom);
      if (draw < 26) return capacity_now;
      if (draw < 32) return capacity_now + 1'b1;
      if (draw < 46) begin
         if (bins_open == 0) return capacity_now;
         slot = $urandom_range(bins_open - 1);
         return bin_room_left[slot] + ITEM_W'($urandom_range(1));
      end
      if (draw < 76) return ITEM_W'($urandom_range(cap, cap / 3));
      return ITEM_W'($urandom_range(cap / 4));
   endfunction

   task automatic drop_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   // present one item and wait until it is taken
   task automatic send_item(input logic [ITEM_W-1:0] size, input logic start,
                            input logic checked, input result_type want);
      result_type predicted;
      req_valid <= 1'b1;
      req_item_size <= size;
      req_start_new <= start;
      valid_up = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = place_item(size, start);
      placements_due.insert(placements_due.size(), checked ? want : predicted);
      items_sent++;
   endtask

   // random sender gap, mostly short, now and then long
   task automatic pause_sender(input bit quiet);
      int draw;
      int gap;
      draw = $urandom_range(99);
      if (quiet || draw < 50) gap = 0;
      else if (draw < 85) gap = $urandom_range(3, 1);
      else if (draw < 95) gap = $urandom_range(8, 4);
      else gap = $urandom_range(40, 10);
      if (gap > 0) begin
         drop_valid();
         req_item_size <= ITEM_W'($urandom);
         req_start_new <= 1'(($urandom));
         repeat (gap) @(posedge clock);
      end
   endtask

   // capacity is only changed with nothing in flight
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drop_valid();
      while (placements_due.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_now = cap;
      cap_writes++;
   endtask

   // receiver stall: runs of free cycles and runs of stall
   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else begin
         stall_draw = $urandom_range(99);
         if (stall_draw < 15) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(60, 20);
         end else if (stall_draw < 55) begin
            rsp_stall <= 1'b0;
            stall_run <= 0;
         end else if (stall_draw < 90) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(2);
         end else begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(40, 8);
         end
      end
   end

   // result check against the oldest pending placement
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_oversize) oversize_seen++;
         if (rsp_no_room) drops_seen++;
         if (placements_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result: bin %0d in use %0d",
                                      rsp_bin_index, rsp_bins_in_use));
         end else begin
            placement_head = placements_due.pop_front();
            if (rsp_bin_index !== placement_head.bin_index)
               report_mismatch($sformatf("result %0d bin_index %0d, want %0d", results_seen,
                                         rsp_bin_index, placement_head.bin_index));
            if (rsp_opened_new !== placement_head.opened_new)
               report_mismatch($sformatf("result %0d opened_new %0b, want %0b", results_seen,
                                         rsp_opened_new, placement_head.opened_new));
            if (rsp_oversize !== placement_head.oversize)
               report_mismatch($sformatf("result %0d oversize %0b, want %0b", results_seen,
                                         rsp_oversize, placement_head.oversize));
            if (rsp_no_room !== placement_head.no_room)
               report_mismatch($sformatf("result %0d no_room %0b, want %0b", results_seen,
                                         rsp_no_room, placement_head.no_room));
            if (rsp_bins_in_use !== placement_head.bins_in_use)
               report_mismatch($sformatf("result %0d bins_in_use %0d, want %0d", results_seen,
                                         rsp_bins_in_use, placement_head.bins_in_use));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d results pending", placements_due.size());
         $display("tb_first_fit_bin_packer_core NOT OK");
         $finish;
      end
   end

   initial begin
      int row;
      int rep;
      int phase_len;
      int n;
      int draw;
      bit quiet;
      logic [CAP_W-1:0] cap;
      logic start;

      bins_open = 0;
      capacity_now = CAP_RESET;
      foreach (bin_room_left[k]) bin_room_left[k] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan
      for (row = 0; row < PLAN_ROWS; row++) begin
         if (DIRECTED_PLAN[row].kind == ROW_CAP) begin
            write_capacity(DIRECTED_PLAN[row].value);
         end else begin
            for (rep = 0; rep < int'(DIRECTED_PLAN[row].reps); rep++) begin
               start = DIRECTED_PLAN[row].start && (rep == 0);
               send_item(DIRECTED_PLAN[row].value, start,
                         DIRECTED_PLAN[row].checked, DIRECTED_PLAN[row].want);
               pause_sender(1'b0);
            end
         end
      end

      // random phases, each under its own capacity
      while (random_sent < RANDOM_ITEMS) begin
         draw = $urandom_range(9);
         case (draw)
            0: cap = '0;
            1: cap = 16'd1;
            2: cap = 16'hFFFF;
            3: cap = 16'hFFFE;
            4, 5, 6: cap = CAP_W'($urandom_range(400, 2));
            default: cap = CAP_W'($urandom_range(65535, 1));
         endcase
         write_capacity(cap);
         phase_len = ($urandom_range(99) < 15) ? $urandom_range(110, 70) : $urandom_range(40, 3);
         quiet = ($urandom_range(4) == 0);
         for (n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
            if (n == 0) start = ($urandom_range(3) != 0);
            else start = ($urandom_range(49) == 0);
            send_item(pick_size(), start, 1'b0, NO_WANT);
            random_sent++;
            pause_sender(quiet);
         end
      end

      // drain, then watch for stray results
      drop_valid();
      while (placements_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("packed %0d items over %0d capacity settings, %0d results checked",
               items_sent, cap_writes, results_seen);
      $display("%0d oversize placements, %0d dropped items, %0d mismatches",
               oversize_seen, drops_seen, mismatches);
      if (mismatches == 0 && placements_due.size() == 0) begin
         $display("tb_first_fit_bin_packer_core OK");
      end else begin
         $display("tb_first_fit_bin_packer_core NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
